// ----- src/pes_pkg.sv -----
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants for product_except_self_top.
// Holds the transfer payload structs, the default list depth and the
// sequencer state type.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int DATA_W      = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product;
    logic                     is_final;
    logic                     truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BRD,
    ST_BPRE,
    ST_BSUF,
    ST_EMIT
  } pes_state_t;

endpackage

// ----- src/product_except_self_top.sv -----
// ----------------------------------------------------------------------------
// product_except_self_top: product of all other list elements.
// Non-final elements are stored while idle. After the final transfer the block
// reads the stored data, then folds each stored element, last to first, on the
// one shared 32x32 multiplier (prefix fold, then suffix), then emits one result
// per element, in order; busy stays high until the last result is out.
// Results cannot be stalled. Sync reset empties the list, not the memories.
// ----------------------------------------------------------------------------
module product_except_self_top #(
  parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pes_pkg::in_item_t   in_item,
  output logic                out_valid,
  output pes_pkg::out_item_t  out_item
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW    = pes_pkg::DATA_W;

  logic [DW-1:0] elem_mem   [MAX_LEN];
  logic [DW-1:0] prefix_mem [MAX_LEN];

  pes_pkg::pes_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [DW-1:0]    prefix_next_r, prefix_next_nxt;
  logic [DW-1:0]    suffix_r, suffix_nxt;
  logic [DW-1:0]    elem_rd_r, prefix_rd_r;

  logic             accept, room;
  logic             sel_pre, sel_suf;
  logic [DW-1:0]    mul_a, mul_b;
  logic [2*DW-1:0]  mul_full;
  logic [DW-1:0]    mul_lo;

  assign accept = start && !busy;
  assign room   = (count_r < CNT_W'(MAX_LEN));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pes_pkg::ST_IDLE: if (accept && in_item.is_last) state_nxt = pes_pkg::ST_BRD;
      pes_pkg::ST_BRD:  state_nxt = pes_pkg::ST_BPRE;
      pes_pkg::ST_BPRE: state_nxt = pes_pkg::ST_BSUF;
      pes_pkg::ST_BSUF: begin
        state_nxt = (idx_r == '0) ? pes_pkg::ST_EMIT : pes_pkg::ST_BPRE;
      end
      pes_pkg::ST_EMIT: if (idx_r == last_idx_r) state_nxt = pes_pkg::ST_IDLE;
      default:          state_nxt = pes_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    sel_pre   = 1'b0;
    sel_suf   = 1'b0;
    case (state_r)
      pes_pkg::ST_IDLE: busy      = 1'b0;
      pes_pkg::ST_BRD:  busy      = 1'b1;
      pes_pkg::ST_BPRE: sel_pre   = 1'b1;
      pes_pkg::ST_BSUF: sel_suf   = 1'b1;
      pes_pkg::ST_EMIT: out_valid = 1'b1;
      default:          busy      = 1'b1;
    endcase
  end

  // The one shared multiplier; only the low word is kept.
  always_comb begin
    if (sel_pre) begin
      mul_a = prefix_rd_r;
      mul_b = suffix_r;
    end else if (sel_suf) begin
      mul_a = suffix_r;
      mul_b = elem_rd_r;
    end else begin
      mul_a = prefix_next_r;
      mul_b = in_item.value;
    end
  end

  assign mul_full = mul_a * mul_b;
  assign mul_lo   = mul_full[DW-1:0];

  // Datapath next values.
  always_comb begin
    count_nxt       = count_r;
    overflow_nxt    = overflow_r;
    idx_nxt         = idx_r;
    last_idx_nxt    = last_idx_r;
    prefix_next_nxt = prefix_next_r;
    suffix_nxt      = suffix_r;
    case (state_r)
      pes_pkg::ST_IDLE: begin
        if (accept) begin
          if (room) begin
            count_nxt       = count_r + CNT_W'(1);
            prefix_next_nxt = mul_lo;
          end else begin
            overflow_nxt = 1'b1;
          end
          if (in_item.is_last) begin
            // Index of the last stored element, either this one or the last slot.
            idx_nxt      = room ? count_r[IDX_W-1:0] : IDX_W'(MAX_LEN - 1);
            last_idx_nxt = idx_nxt;
            suffix_nxt   = DW'(1);
          end
        end
      end
      pes_pkg::ST_BSUF: begin
        suffix_nxt = mul_lo;
        if (idx_r != '0) idx_nxt = idx_r - IDX_W'(1);
      end
      pes_pkg::ST_EMIT: begin
        if (idx_r == last_idx_r) begin
          count_nxt       = '0;
          overflow_nxt    = 1'b0;
          prefix_next_nxt = DW'(1);
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pes_pkg::ST_IDLE;
      count_r       <= '0;
      overflow_r    <= 1'b0;
      idx_r         <= '0;
      last_idx_r    <= '0;
      prefix_next_r <= DW'(1);
      suffix_r      <= DW'(1);
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      overflow_r    <= overflow_nxt;
      idx_r         <= idx_nxt;
      last_idx_r    <= last_idx_nxt;
      prefix_next_r <= prefix_next_nxt;
      suffix_r      <= suffix_nxt;
    end
  end

  // Memories: read at the next index so the data lines up with idx_r.
  always_ff @(posedge clk) begin
    if (accept && room) begin
      elem_mem[count_r[IDX_W-1:0]]   <= in_item.value;
      prefix_mem[count_r[IDX_W-1:0]] <= prefix_next_r;
    end else if (sel_pre) begin
      prefix_mem[idx_r] <= mul_lo;
    end
    elem_rd_r   <= elem_mem[idx_nxt];
    prefix_rd_r <= prefix_mem[idx_nxt];
  end

  always_comb begin
    out_item.product   = prefix_rd_r;
    out_item.is_final  = (idx_r == last_idx_r);
    out_item.truncated = overflow_r;
  end

endmodule
